/* sv/hierarchical_transform_propagation_core_assert.svh */
`ifndef HIERARCHICAL_TRANSFORM_PROPAGATION_CORE_ASSERT_SVH
`define HIERARCHICAL_TRANSFORM_PROPAGATION_CORE_ASSERT_SVH

// same-cycle implication, checked while out of reset
`define HTPC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked while out of reset
`define HTPC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/hftp_pkg.sv */
package hftp_pkg;

    localparam int MAX_NODES = 256;
    localparam int IDX_W     = $clog2(MAX_NODES);
    localparam int WORD_W    = 32;
    localparam int ENTRY_W   = 6 * WORD_W;
    localparam int MUL_W     = 33;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int ACC_W     = PROD_W + 2;

    // odd sine series coefficients, q30
    localparam logic signed [MUL_W-1:0] Q30_C1 = 33'sd1686629713;
    localparam logic signed [MUL_W-1:0] Q30_C3 = 33'sd693598669;
    localparam logic signed [MUL_W-1:0] Q30_C5 = 33'sd85569306;
    localparam logic signed [MUL_W-1:0] Q30_C7 = 33'sd5026994;
    localparam logic signed [MUL_W-1:0] Q30_C9 = 33'sd172272;

    // micro step boundaries
    localparam logic [4:0] ST_TRIG_G   = 5'd6;
    localparam logic [4:0] ST_LOC      = 5'd12;
    localparam logic [4:0] ST_LOC_LAST = 5'd15;
    localparam logic [4:0] ST_GLB      = 5'd16;
    localparam logic [4:0] ST_LAST     = 5'd27;

    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-64'sd2147483648);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    typedef struct packed {
        logic mul_en;
        logic acc_load;
    } t_mac_ctl;

    typedef struct packed {
        logic                     sat;
        logic signed [WORD_W-1:0] val;
    } t_rnd;

    // round half up from q32 to q16 and clamp to 32 bits
    function automatic t_rnd rnd_sat(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] w;
        t_rnd r;
        w = (v + ACC_W'(32768)) >>> 16;
        if (w > SAT_MAX) begin
            r.sat = 1'b1;
            r.val = SAT_MAX[WORD_W-1:0];
        end else if (w < SAT_MIN) begin
            r.sat = 1'b1;
            r.val = SAT_MIN[WORD_W-1:0];
        end else begin
            r.sat = 1'b0;
            r.val = w[WORD_W-1:0];
        end
        return r;
    endfunction

endpackage

/* sv/hftp_store.sv */
module hftp_store (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [hftp_pkg::IDX_W-1:0]   i_waddr,
    input  logic [hftp_pkg::ENTRY_W-1:0] i_wdata,
    input  logic                         i_re,
    input  logic [hftp_pkg::IDX_W-1:0]   i_raddr,
    output logic [hftp_pkg::ENTRY_W-1:0] o_rdata
);
    import hftp_pkg::*;

    logic [ENTRY_W-1:0] r_mem [MAX_NODES];
    logic [ENTRY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* sv/hftp_mac.sv */
module hftp_mac (
    input  logic                              i_clk,
    input  hftp_pkg::t_mac_ctl                i_ctl,
    input  logic signed [hftp_pkg::MUL_W-1:0] i_a,
    input  logic signed [hftp_pkg::MUL_W-1:0] i_b,
    input  logic signed [hftp_pkg::ACC_W-1:0] i_addend,
    output logic signed [hftp_pkg::PROD_W-1:0] o_prod,
    output logic signed [hftp_pkg::ACC_W-1:0] o_sum
);
    import hftp_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= i_a * i_b;
        end
        if (i_ctl.acc_load) begin
            r_acc <= ACC_W'(r_prod) + i_addend;
        end
    end

    assign o_prod = r_prod;
    assign o_sum  = r_acc + ACC_W'(r_prod);
endmodule

/* sv/hierarchical_transform_propagation_core.sv */
// an item is accepted only in idle and runs the sine/cosine, local and global steps (a root skips the global ones)
// no new item is taken until its result is loaded into the output register; all products go through
// one shared 33x33 multiplier (12 sine/cosine, 4 local, 12 global)
// the parent entry is read from the store at the start of an item, the result written at the end
// reset (synchronous, active low) clears control and output valid, the store keeps its contents
`include "hierarchical_transform_propagation_core_assert.svh"

module hierarchical_transform_propagation_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_slot,
    input  logic [7:0]         i_parent_slot,
    input  logic               i_is_root,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic [15:0]        i_angle,
    input  logic signed [31:0] i_scale_x,
    input  logic signed [31:0] i_scale_y,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [7:0]         o_out_slot,
    output logic signed [31:0] o_col0_row0,
    output logic signed [31:0] o_col0_row1,
    output logic signed [31:0] o_col1_row0,
    output logic signed [31:0] o_col1_row1,
    output logic signed [31:0] o_trans_x,
    output logic signed [31:0] o_trans_y,
    output logic               o_saturated
);
    import hftp_pkg::*;

    // control
    t_state     r_state;
    logic [4:0] r_step;
    logic       r_ph;
    logic       r_ovalid;

    // captured item
    logic [7:0]                r_slot;
    logic [7:0]                r_pslot;
    logic                      r_root;
    logic signed [WORD_W-1:0]  r_px;
    logic signed [WORD_W-1:0]  r_py;
    logic [15:0]               r_ang;
    logic signed [WORD_W-1:0]  r_sx;
    logic signed [WORD_W-1:0]  r_sy;

    // working values
    logic signed [MUL_W-1:0]   r_t2;
    logic signed [MUL_W-1:0]   r_p;
    logic [16:0]               r_sf;
    logic [16:0]               r_sg;
    logic signed [WORD_W-1:0]  r_loc [4];
    logic signed [WORD_W-1:0]  r_res [6];
    logic                      r_sat;

    // output register
    logic [7:0]                r_o_slot;
    logic signed [WORD_W-1:0]  r_o_m [6];
    logic                      r_o_sat;

    // datapath signals
    t_mac_ctl                  w_ctl;
    logic signed [MUL_W-1:0]   w_a;
    logic signed [MUL_W-1:0]   w_b;
    logic signed [ACC_W-1:0]   w_addend;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [ACC_W-1:0]   w_sum;
    logic [ENTRY_W-1:0]        w_rdata;
    logic signed [WORD_W-1:0]  w_par [6];
    logic [ENTRY_W-1:0]        w_wdata;
    logic                      w_we;
    logic                      w_re;
    logic                      w_accept;
    logic                      w_out_load;

    logic [14:0]               w_u;
    logic signed [MUL_W-1:0]   w_t;
    logic [2:0]                w_k;
    logic signed [PROD_W-1:0]  w_sh30;
    logic signed [PROD_W-1:0]  w_q;
    logic [16:0]               w_qsat;
    logic signed [17:0]        w_sin;
    logic signed [17:0]        w_cos;
    logic [4:0]                w_j;
    logic [2:0]                w_e;
    logic                      w_second;
    logic [1:0]                w_i;
    logic                      w_row;
    t_rnd                      w_loc_rnd;
    t_rnd                      w_glb_rnd;
    logic                      w_in_trig;
    logic                      w_in_loc;
    logic                      w_last;

    assign w_accept   = i_valid && o_ready;
    assign o_ready    = (r_state == S_IDLE);
    assign w_out_load = (r_state == S_DONE) && (!r_ovalid || i_ready);
    assign w_we       = w_out_load;
    assign w_re       = (r_state == S_RUN) && (r_step == '0) && !r_ph;

    assign w_in_trig  = (r_step < ST_LOC);
    assign w_in_loc   = !w_in_trig && (r_step < ST_GLB);
    assign w_last     = (r_step == ST_LAST) || (r_root && (r_step == ST_LOC_LAST));

    // parent global matrix words from the store
    always_comb begin
        for (int n = 0; n < 6; n++) begin
            w_par[n] = w_rdata[n*WORD_W +: WORD_W];
        end
    end

    // quarter-wave argument: f for the first pass, 16384 - f for the second
    assign w_u = (r_step < ST_TRIG_G) ? {1'b0, r_ang[13:0]}
                                      : 15'(15'd16384 - {1'b0, r_ang[13:0]});
    assign w_t = $signed({2'b00, w_u, 16'h0000});
    assign w_k = (r_step < ST_TRIG_G) ? r_step[2:0] : 3'(r_step - ST_TRIG_G);

    assign w_sh30 = w_prod >>> 30;
    assign w_q    = (w_sh30 + PROD_W'(8192)) >>> 14;
    always_comb begin
        if (w_q < 0) begin
            w_qsat = '0;
        end else if (w_q > PROD_W'(65536)) begin
            w_qsat = 17'h10000;
        end else begin
            w_qsat = w_q[16:0];
        end
    end

    // quadrant folding
    always_comb begin
        case (r_ang[15:14])
            2'd0: begin
                w_sin = $signed({1'b0, r_sf});
                w_cos = $signed({1'b0, r_sg});
            end
            2'd1: begin
                w_sin = $signed({1'b0, r_sg});
                w_cos = -$signed({1'b0, r_sf});
            end
            2'd2: begin
                w_sin = -$signed({1'b0, r_sf});
                w_cos = -$signed({1'b0, r_sg});
            end
            default: begin
                w_sin = -$signed({1'b0, r_sg});
                w_cos = $signed({1'b0, r_sf});
            end
        endcase
    end

    // global step decode: entry e, second product of the pair, column i, row
    assign w_j      = r_step - ST_GLB;
    assign w_e      = w_j[3:1];
    assign w_second = w_j[0];
    assign w_i      = w_e[2:1];
    assign w_row    = w_e[0];

    // operand selection
    always_comb begin
        w_a      = '0;
        w_b      = '0;
        w_addend = '0;
        if (w_in_trig) begin
            case (w_k)
                3'd0: begin
                    w_a = w_t;
                    w_b = w_t;
                end
                3'd1: begin
                    w_a = Q30_C9;
                    w_b = r_t2;
                end
                3'd5: begin
                    w_a = r_p;
                    w_b = w_t;
                end
                default: begin
                    w_a = r_p;
                    w_b = r_t2;
                end
            endcase
        end else if (w_in_loc) begin
            case (r_step[1:0])
                2'd0: begin
                    w_a = MUL_W'(r_sx);
                    w_b = MUL_W'(w_cos);
                end
                2'd1: begin
                    w_a = MUL_W'(r_sx);
                    w_b = MUL_W'(w_sin);
                end
                2'd2: begin
                    w_a = -MUL_W'(r_sy);
                    w_b = MUL_W'(w_sin);
                end
                default: begin
                    w_a = MUL_W'(r_sy);
                    w_b = MUL_W'(w_cos);
                end
            endcase
        end else begin
            if (w_second) begin
                w_a = MUL_W'(w_row ? w_par[3] : w_par[2]);
                case (w_i)
                    2'd0:    w_b = MUL_W'(r_loc[1]);
                    2'd1:    w_b = MUL_W'(r_loc[3]);
                    default: w_b = MUL_W'(r_py);
                endcase
            end else begin
                w_a = MUL_W'(w_row ? w_par[1] : w_par[0]);
                case (w_i)
                    2'd0:    w_b = MUL_W'(r_loc[0]);
                    2'd1:    w_b = MUL_W'(r_loc[2]);
                    default: w_b = MUL_W'(r_px);
                endcase
            end
            if (w_i == 2'd2) begin
                w_addend = ACC_W'(w_row ? w_par[5] : w_par[4]) <<< 16;
            end
        end
    end

    assign w_ctl.mul_en   = (r_state == S_RUN) && !r_ph;
    assign w_ctl.acc_load = (r_state == S_RUN) && r_ph && !w_in_trig && !w_in_loc
                            && !w_second;

    assign w_loc_rnd = rnd_sat(ACC_W'(w_prod));
    assign w_glb_rnd = rnd_sat(w_sum);

    // a root stores its local matrix as is
    assign w_wdata = r_root ? {r_py, r_px, r_loc[3], r_loc[2], r_loc[1], r_loc[0]}
                            : {r_res[5], r_res[4], r_res[3], r_res[2], r_res[1], r_res[0]};

    hftp_mac u_mac (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_a      (w_a),
        .i_b      (w_b),
        .i_addend (w_addend),
        .o_prod   (w_prod),
        .o_sum    (w_sum)
    );

    hftp_store u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_slot[IDX_W-1:0]),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_pslot[IDX_W-1:0]),
        .o_rdata (w_rdata)
    );

    // sequencer: each product takes an issue phase and a consume phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= '0;
            r_ph     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_step  <= '0;
                        r_ph    <= 1'b0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_ph <= !r_ph;
                    if (r_ph) begin
                        if (w_last) begin
                            r_state <= S_DONE;
                        end else begin
                            r_step <= r_step + 5'd1;
                        end
                    end
                end
                S_DONE: begin
                    if (w_out_load) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_slot  <= i_slot;
            r_pslot <= i_parent_slot;
            r_root  <= i_is_root;
            r_px    <= i_pos_x;
            r_py    <= i_pos_y;
            r_ang   <= i_angle;
            r_sx    <= i_scale_x;
            r_sy    <= i_scale_y;
            r_sat   <= 1'b0;
        end
        if ((r_state == S_RUN) && r_ph) begin
            if (w_in_trig) begin
                case (w_k)
                    3'd0: r_t2 <= MUL_W'(w_sh30);
                    3'd1: r_p  <= MUL_W'(PROD_W'(Q30_C7) - w_sh30);
                    3'd2: r_p  <= MUL_W'(PROD_W'(Q30_C5) - w_sh30);
                    3'd3: r_p  <= MUL_W'(PROD_W'(Q30_C3) - w_sh30);
                    3'd4: r_p  <= MUL_W'(PROD_W'(Q30_C1) - w_sh30);
                    default: begin
                        if (r_step < ST_TRIG_G) begin
                            r_sf <= w_qsat;
                        end else begin
                            r_sg <= w_qsat;
                        end
                    end
                endcase
            end else if (w_in_loc) begin
                r_loc[r_step[1:0]] <= w_loc_rnd.val;
                r_sat              <= r_sat | w_loc_rnd.sat;
            end else if (w_second) begin
                r_res[w_e] <= w_glb_rnd.val;
                r_sat      <= r_sat | w_glb_rnd.sat;
            end
        end
        if (w_out_load) begin
            r_o_slot <= r_slot;
            r_o_sat  <= r_sat;
            for (int n = 0; n < 6; n++) begin
                r_o_m[n] <= w_wdata[n*WORD_W +: WORD_W];
            end
        end
    end

    assign o_valid     = r_ovalid;
    assign o_out_slot  = r_o_slot;
    assign o_col0_row0 = r_o_m[0];
    assign o_col0_row1 = r_o_m[1];
    assign o_col1_row0 = r_o_m[2];
    assign o_col1_row1 = r_o_m[3];
    assign o_trans_x   = r_o_m[4];
    assign o_trans_y   = r_o_m[5];
    assign o_saturated = r_o_sat;

    `HTPC_ASSERT_IMP(a_busy_not_ready, r_state != S_IDLE, !o_ready, "ready while busy")
    `HTPC_ASSERT_IMP(a_step_range, r_state == S_RUN, r_step <= ST_LAST, "step out of range")
    `HTPC_ASSERT_NXT(a_accept_starts, w_accept, (r_state == S_RUN) && (r_step == '0) && !r_ph, "item did not start")
    `HTPC_ASSERT_NXT(a_write_shows, w_we, o_valid && (o_out_slot == $past(r_slot)), "stored item not shown")
endmodule

/* dv/testbench.sv */
module testbench;
    import hftp_pkg::*;

    localparam int CLK_LIMIT = 2000000;

    typedef struct {
        logic [7:0]         slot;
        logic [7:0]         pslot;
        logic               root;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic [15:0]        ang;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
    } node_t;

    typedef struct {
        logic [7:0]         slot;
        logic [5:0][31:0]   m;
        logic               sat;
    } xform_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [7:0]         i_slot;
    logic [7:0]         i_parent_slot;
    logic               i_is_root;
    logic signed [31:0] i_pos_x;
    logic signed [31:0] i_pos_y;
    logic [15:0]        i_angle;
    logic signed [31:0] i_scale_x;
    logic signed [31:0] i_scale_y;
    logic               o_valid;
    logic               i_ready;
    logic [7:0]         o_out_slot;
    logic signed [31:0] o_col0_row0;
    logic signed [31:0] o_col0_row1;
    logic signed [31:0] o_col1_row0;
    logic signed [31:0] o_col1_row1;
    logic signed [31:0] o_trans_x;
    logic signed [31:0] o_trans_y;
    logic               o_saturated;

    hierarchical_transform_propagation_core i_dut (.*);

    // pending nodes, expected global matrices, mirror of the matrix store
    node_t              node_q[$];
    xform_t             global_q[$];
    logic signed [31:0] mat_store[256][6];
    bit                 slot_written[256];
    int                 written_list[$];

    int      mismatches = 0;
    int      cycles = 0;
    int      accepted = 0;
    int      checked = 0;
    int      sat_seen = 0;
    int      child_seen = 0;
    int      burst_left = 0;
    int      gap_left = 0;
    int      stall_mode = 0;
    bit      stim_done = 0;

    // clock
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // quarter wave sine, q30 odd series, rounded to q16
    function automatic longint quarter_sin(input int unsigned f);
        longint t, t2, p, r;
        t  = longint'(f) << 16;
        t2 = (t * t) >>> 30;
        p  = Q30_C9;
        p  = Q30_C7 - ((p * t2) >>> 30);
        p  = Q30_C5 - ((p * t2) >>> 30);
        p  = Q30_C3 - ((p * t2) >>> 30);
        p  = Q30_C1 - ((p * t2) >>> 30);
        r  = (p * t) >>> 30;
        r  = (r + 8192) >>> 14;
        if (r < 0) r = 0;
        if (r > 65536) r = 65536;
        return r;
    endfunction

    // exact wide product
    function automatic logic signed [127:0] wmul(input longint a, input longint b);
        logic signed [127:0] x, y;
        x = a;
        y = b;
        return x * y;
    endfunction

    // q32 sum to q16.16, round half up, clamp and flag
    function automatic logic signed [31:0] round_clamp(input logic signed [127:0] v,
                                                        inout bit clamped);
        logic signed [127:0] w;
        w = (v + 128'sd32768) >>> 16;
        if (w > 128'sd2147483647) begin
            clamped = 1;
            return 32'sh7fffffff;
        end
        if (w < -128'sd2147483648) begin
            clamped = 1;
            return 32'sh80000000;
        end
        return w[31:0];
    endfunction

    // global matrix of one node; updates the store mirror
    function automatic xform_t propagate(input node_t n);
        xform_t e;
        longint sf, sg, s, c;
        longint loc[6];
        longint par[6];
        logic signed [31:0] res[6];
        logic signed [127:0] a0, a1;
        bit clamped;
        sf = quarter_sin(n.ang[13:0]);
        sg = quarter_sin(16384 - n.ang[13:0]);
        case (n.ang[15:14])
            2'd0: begin s = sf;  c = sg;  end
            2'd1: begin s = sg;  c = -sf; end
            2'd2: begin s = -sf; c = -sg; end
            default: begin s = -sg; c = sf; end
        endcase
        clamped = 0;
        loc[0] = round_clamp(wmul(n.sx, c), clamped);
        loc[1] = round_clamp(wmul(n.sx, s), clamped);
        loc[2] = round_clamp(wmul(-longint'(n.sy), s), clamped);
        loc[3] = round_clamp(wmul(n.sy, c), clamped);
        loc[4] = n.px;
        loc[5] = n.py;
        if (n.root) begin
            for (int k = 0; k < 6; k++) res[k] = loc[k];
        end else begin
            for (int k = 0; k < 6; k++) par[k] = mat_store[n.pslot][k];
            for (int i = 0; i < 3; i++) begin
                a0 = wmul(par[0], loc[2*i]) + wmul(par[2], loc[2*i+1]);
                a1 = wmul(par[1], loc[2*i]) + wmul(par[3], loc[2*i+1]);
                if (i == 2) begin
                    a0 = a0 + wmul(par[4], 65536);
                    a1 = a1 + wmul(par[5], 65536);
                end
                res[2*i]   = round_clamp(a0, clamped);
                res[2*i+1] = round_clamp(a1, clamped);
            end
        end
        for (int k = 0; k < 6; k++) begin
            mat_store[n.slot][k] = res[k];
            e.m[k] = res[k];
        end
        e.slot = n.slot;
        e.sat  = clamped;
        return e;
    endfunction

    // q16.16 value: mostly moderate, sometimes full range or extreme
    function automatic logic [31:0] rand_q16(input int unsigned span);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 15) return $urandom;
        if (pick < 19) return 32'h7fffffff;
        if (pick < 22) return 32'h80000000;
        return 32'($urandom_range(0, 2 * span)) - 32'(span);
    endfunction

    task automatic add_node(input logic [7:0] slot, input logic [7:0] pslot,
                            input logic root, input logic [31:0] px,
                            input logic [31:0] py, input logic [15:0] ang,
                            input logic [31:0] sx, input logic [31:0] sy);
        node_t n;
        n = '{slot, pslot, root, px, py, ang, sx, sy};
        node_q.push_back(n);
        if (!slot_written[slot]) begin
            slot_written[slot] = 1;
            written_list.push_back(slot);
        end
    endtask

    // random tree: mostly children of already built nodes, some new roots
    task automatic add_random_node();
        logic [7:0] slot, pslot;
        logic root;
        slot  = $urandom;
        pslot = $urandom;
        root  = ($urandom_range(0, 99) < 15);
        if (!root) pslot = written_list[$urandom_range(0, written_list.size() - 1)];
        // child right behind its parent exercises a store read of the entry just written
        if (!root && $urandom_range(0, 3) == 0 && node_q.size() > 0)
            pslot = node_q[$].slot;
        if (!root && !slot_written[pslot]) pslot = written_list[0];
        add_node(slot, pslot, root, rand_q16(32'h0100_0000), rand_q16(32'h0100_0000),
                 $urandom, rand_q16(32'h0002_0000), rand_q16(32'h0002_0000));
    endtask

    // sender: bursts of random length with gaps, prediction at accept
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                global_q.push_back(propagate('{i_slot, i_parent_slot, i_is_root, i_pos_x,
                    i_pos_y, i_angle, i_scale_x, i_scale_y}));
                accepted++;
                if (!i_is_root) child_seen++;
            end
            if (!i_valid || o_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (node_q.size() > 0) begin
                    node_t n;
                    n = node_q.pop_front();
                    i_valid       <= 1'b1;
                    i_slot        <= n.slot;
                    i_parent_slot <= n.pslot;
                    i_is_root     <= n.root;
                    i_pos_x       <= n.px;
                    i_pos_y       <= n.py;
                    i_angle       <= n.ang;
                    i_scale_x     <= n.sx;
                    i_scale_y     <= n.sy;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 12);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 90);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: ready follows a stall mode that is picked anew at random
    always @(posedge i_clk) begin
        cycles++;
        if (cycles % 400 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= $urandom_range(0, 1);
            2: i_ready <= ($urandom_range(0, 9) == 0);
            default: i_ready <= ((cycles % 7) < 3);
        endcase
        if (cycles > CLK_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("testbench: FAIL");
            $finish;
        end
    end

    // result check against the oldest expected matrix
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            xform_t e, got;
            got.slot = o_out_slot;
            got.m    = {o_trans_y, o_trans_x, o_col1_row1, o_col1_row0, o_col0_row1, o_col0_row0};
            got.sat  = o_saturated;
            if (global_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected item slot %0d", got.slot);
            end else begin
                e = global_q.pop_front();
                checked++;
                if (e.sat) sat_seen++;
                if (e != got) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch slot exp %0d got %0d sat exp %0b got %0b\n  exp %p\n  got %p",
                                 e.slot, got.slot, e.sat, got.sat, e.m, got.m);
                end
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_slot = '0;
        i_parent_slot = '0;
        i_is_root = 1'b0;
        i_pos_x = '0;
        i_pos_y = '0;
        i_angle = '0;
        i_scale_x = '0;
        i_scale_y = '0;

        // directed: quadrant boundaries, extremes, self parent, saturation
        add_node(8'd0, 8'd0, 1, 32'h0001_0000, 32'hffff_0000, 16'd0, 32'h0001_0000, 32'h0001_0000);
        add_node(8'd1, 8'd0, 0, 32'h0002_0000, 32'h0003_0000, 16'd16384, 32'h0001_0000,
                 32'h0002_0000);
        add_node(8'd2, 8'd1, 0, 32'h0, 32'h0, 16'd32768, 32'h0000_8000, 32'h0001_0000);
        add_node(8'd3, 8'd2, 0, 32'h1, 32'hffff_ffff, 16'd49152, 32'h0001_0000, 32'hffff_0000);
        add_node(8'd255, 8'd3, 0, 32'h7fff_ffff, 32'h8000_0000, 16'd65535, 32'h0001_0000,
                 32'h0001_0000);
        add_node(8'd254, 8'd0, 1, 32'h8000_0000, 32'h7fff_ffff, 16'd8192, 32'h7fff_ffff,
                 32'h8000_0000);
        add_node(8'd253, 8'd254, 0, 32'h7fff_ffff, 32'h7fff_ffff, 16'd1, 32'h7fff_ffff,
                 32'h7fff_ffff);
        add_node(8'd253, 8'd253, 0, 32'h0, 32'h0, 16'd24576, 32'h8000_0000, 32'h8000_0000);
        add_node(8'd1, 8'd1, 0, 32'h0001_0000, 32'h0, 16'd16383, 32'h0001_0000, 32'h0001_0000);
        add_node(8'd4, 8'd255, 0, 32'h0, 32'h0, 16'd40000, 32'h0, 32'h0);
        add_node(8'd5, 8'd5, 1, 32'hffff_ffff, 32'h0, 16'd49151, 32'hffff_ffff, 32'h1);
        add_node(8'd6, 8'd5, 0, 32'h0, 32'h0, 16'd57344, 32'h0002_0000, 32'hfffe_0000);
        add_node(8'd7, 8'd6, 0, 32'h1234_5678, 32'hedcb_a988, 16'd32767, 32'h0001_8000,
                 32'h0000_4000);
        add_node(8'd0, 8'd7, 0, 32'h0, 32'h0, 16'd16385, 32'h0001_0000, 32'h0001_0000);
        for (int k = 0; k < 1690; k++) add_random_node();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (node_q.size() == 0 && !i_valid);
        wait (global_q.size() == 0);
        repeat (100) @(posedge i_clk);

        $display("%0d nodes sent, %0d children, %0d matrices checked, %0d with clamping",
                 accepted, child_seen, checked, sat_seen);
        if (mismatches == 0 && global_q.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("%0d mismatches, %0d left over", mismatches, global_q.size());
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
